>>> hdl/dasf_pkg.sv
// shared types and constants for the dual audio sample fifo
`timescale 1ns / 1ps
package dasf_pkg;

    // request codes of an input word
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_TIMER = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_LOAD,
        S_CLEAR,
        S_DONE
    } t_state;

    // configuration register indexes
    localparam logic [1:0] CFG_TSEL_A = 2'd0;
    localparam logic [1:0] CFG_TSEL_B = 2'd1;
    localparam logic [1:0] CFG_FVOL_A = 2'd2;
    localparam logic [1:0] CFG_FVOL_B = 2'd3;

    // largest number of bytes pushed by one write
    localparam logic [2:0] MAX_BYTES = 3'd4;

    // one step command from the sequencer to a channel
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] data;
    } t_chan_cmd;

endpackage

>>> hdl/dasf_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module dasf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/dasf_chan.sv
// one sample channel: queue ram, pointers, fill count and current sample
`timescale 1ns / 1ps
module dasf_chan #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dasf_pkg::t_chan_cmd                i_cmd,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count,
    output logic [7:0]                         o_current
);
    import dasf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_cur, n_cur;
    logic             r_pop_pend, n_pop_pend;
    logic [CNT_W:0]   wsum;
    logic [PTR_W-1:0] waddr;
    logic             we;
    logic [7:0]       rdata;

    // write address: read pointer plus count, wrapped once
    always_comb begin
        wsum  = (CNT_W+1)'(r_rd) + (CNT_W+1)'(r_cnt);
        if (wsum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            wsum = wsum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        waddr = wsum[PTR_W-1:0];
        we    = i_cmd.push && (r_cnt < CNT_W'(QUEUE_DEPTH));
    end

    dasf_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.data),
        .i_raddr (r_rd),
        .o_rdata (rdata)
    );

    // pointer, count and sample updates
    always_comb begin
        n_rd       = r_rd;
        n_cnt      = r_cnt;
        n_cur      = r_cur;
        n_pop_pend = 1'b0;
        if (i_cmd.clear) begin
            n_rd  = '0;
            n_cnt = '0;
            n_cur = '0;
        end else if (we) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_cmd.pop && (r_cnt != '0)) begin
            n_rd       = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            n_cnt      = r_cnt - CNT_W'(1);
            n_pop_pend = 1'b1;
        end
        // ram data for a pop arrives in the cycle after the pop
        if (r_pop_pend) begin
            n_cur = rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd       <= '0;
            r_cnt      <= '0;
            r_cur      <= '0;
            r_pop_pend <= 1'b0;
        end else begin
            r_rd       <= n_rd;
            r_cnt      <= n_cnt;
            r_cur      <= n_cur;
            r_pop_pend <= n_pop_pend;
        end
    end

    assign o_count   = r_cnt;
    assign o_current = r_cur;

    // fill count never passes the queue depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("channel count above depth");

    // a clear leaves the channel empty with a zero sample
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_cnt == '0) && (r_rd == '0) && (r_cur == '0))
        else $error("clear did not empty channel");

    // a pop on an empty queue moves nothing
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop && !i_cmd.push && !i_cmd.clear && (r_cnt == '0))
            |=> $stable(r_rd) && (r_cnt == '0) && !r_pop_pend)
        else $error("pop on empty queue changed state");

endmodule

>>> hdl/dual_audio_sample_fifo_core.sv
// top level: request sequencer, configuration and result register
`timescale 1ns / 1ps
// Two signed 8-bit sample queues, A and B, each in its own RAM with one write
// port. A write word pushes its bytes, least significant first, one byte per
// cycle through the queue's write port (n = 1, 2 or 4 bytes, 3 also accepted,
// 5 to 7 taken as 4), then goes to the result step. A timer event steps
// through pop address, registered RAM read and result. A clear event
// steps through clear and result; a write aimed at no queue, a write of zero
// bytes or an unused request code go straight to the result. The result step
// holds for as long as the output register keeps a word the receiver has not
// taken. The next word is accepted once the sequencer is idle again, even
// while the previous result still waits in the output register. Configuration
// writes take effect at once and should be made only while the block is idle.
module dual_audio_sample_fifo_core #(
    parameter int QUEUE_DEPTH     = 32,
    parameter int REFILL_LEVEL    = 17,
    parameter int B_WINDOW_OFFSET = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic              i_cfg_data,
    // request channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_req_type,
    input  logic [3:0]        i_reg_offset,
    input  logic [31:0]       i_write_data,
    input  logic [2:0]        i_byte_count,
    input  logic [1:0]        i_timer_number,
    input  logic              i_clear_a,
    input  logic              i_clear_b,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [9:0] o_out_sample_a,
    output logic signed [9:0] o_out_sample_b,
    output logic              o_refill_a,
    output logic              o_refill_b,
    output logic [5:0]        o_level_a,
    output logic [5:0]        o_level_b
);
    import dasf_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_state r_state, n_state;

    // configuration registers
    logic r_tsel_a, r_tsel_b, r_fvol_a, r_fvol_b;

    // latched request
    logic [31:0] r_data;
    logic [2:0]  r_nbytes;
    logic [1:0]  r_idx, n_idx;
    logic        r_tgt_a, r_tgt_b;
    logic        r_hit_a, r_hit_b;
    logic        r_clr_a, r_clr_b;

    // result register
    logic              r_out_valid;
    logic signed [9:0] r_samp_a, r_samp_b;
    logic              r_refill_a, r_refill_b;
    logic [5:0]        r_level_a, r_level_b;

    logic       accept;
    logic       load_out;
    logic [2:0] nbytes;
    logic       tgt_a, tgt_b;
    t_chan_cmd  cmd_a, cmd_b;
    logic [CNT_W-1:0] cnt_a, cnt_b;
    logic [7:0]       cur_a, cur_b;
    logic [9:0]       ext_a, ext_b;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);

    // request decode at acceptance
    always_comb begin
        nbytes = (i_byte_count > MAX_BYTES) ? MAX_BYTES : i_byte_count;
        tgt_a  = ({1'b0, i_reg_offset} < 5'(B_WINDOW_OFFSET));
        tgt_b  = !tgt_a && ({1'b0, i_reg_offset} < 5'(2 * B_WINDOW_OFFSET));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsel_a <= 1'b0;
            r_tsel_b <= 1'b0;
            r_fvol_a <= 1'b0;
            r_fvol_b <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TSEL_A: r_tsel_a <= i_cfg_data;
                CFG_TSEL_B: r_tsel_b <= i_cfg_data;
                CFG_FVOL_A: r_fvol_a <= i_cfg_data;
                CFG_FVOL_B: r_fvol_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latch the accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data   <= i_write_data;
            r_nbytes <= nbytes;
            r_tgt_a  <= tgt_a;
            r_tgt_b  <= tgt_b;
            r_hit_a  <= (i_req_type == REQ_TIMER) && ({1'b0, r_tsel_a} == i_timer_number);
            r_hit_b  <= (i_req_type == REQ_TIMER) && ({1'b0, r_tsel_b} == i_timer_number);
            r_clr_a  <= i_clear_a;
            r_clr_b  <= i_clear_b;
        end
    end

    // sequencer next state and channel commands
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        load_out = 1'b0;
        cmd_a    = '0;
        cmd_b    = '0;
        cmd_a.data = r_data[8*r_idx +: 8];
        cmd_b.data = r_data[8*r_idx +: 8];
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    case (i_req_type)
                        REQ_WRITE: begin
                            n_state = ((tgt_a || tgt_b) && (nbytes != '0)) ? S_PUSH : S_DONE;
                        end
                        REQ_TIMER: n_state = S_POP;
                        REQ_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_PUSH: begin
                cmd_a.push = r_tgt_a;
                cmd_b.push = r_tgt_b;
                n_idx      = r_idx + 2'd1;
                if ((3'(r_idx) + 3'd1) == r_nbytes) begin
                    n_state = S_DONE;
                end
            end
            S_POP: begin
                cmd_a.pop = r_hit_a;
                cmd_b.pop = r_hit_b;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_DONE;
            end
            S_CLEAR: begin
                cmd_a.clear = r_clr_a;
                cmd_b.clear = r_clr_b;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    dasf_chan #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_chan_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_a),
        .o_count   (cnt_a),
        .o_current (cur_a)
    );

    dasf_chan #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_chan_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_b),
        .o_count   (cnt_b),
        .o_current (cur_b)
    );

    // sample gain: sign extend, then times 2 or 4
    assign ext_a = {{2{cur_a[7]}}, cur_a};
    assign ext_b = {{2{cur_b[7]}}, cur_b};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_samp_a   <= r_fvol_a ? (ext_a << 2) : (ext_a << 1);
            r_samp_b   <= r_fvol_b ? (ext_b << 2) : (ext_b << 1);
            r_refill_a <= r_hit_a && (32'(cnt_a) < REFILL_LEVEL);
            r_refill_b <= r_hit_b && (32'(cnt_b) < REFILL_LEVEL);
            r_level_a  <= 6'(cnt_a);
            r_level_b  <= 6'(cnt_b);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_sample_a = r_samp_a;
    assign o_out_sample_b = r_samp_b;
    assign o_refill_a     = r_refill_a;
    assign o_refill_b     = r_refill_b;
    assign o_level_a      = r_level_a;
    assign o_level_b      = r_level_b;

endmodule

>>> sim/tb.sv
// testbench for the dual audio sample fifo core: stimulus, prediction and checking
`timescale 1ns / 1ps
module tb;
    import dasf_pkg::*;

    localparam int QDEPTH      = 32;
    localparam int REFILL_LVL  = 17;
    localparam int B_WIN       = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam int PHASE_WORDS = 312;

    // request code the block leaves unused
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // one request word as it crosses the input handshake
    typedef struct packed {
        logic [1:0]  req;
        logic [3:0]  offset;
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic [1:0]  timer;
        logic        clr_a;
        logic        clr_b;
    } t_word;

    // one result word: both scaled samples, refill requests and levels
    typedef struct packed {
        logic signed [9:0] samp_a;
        logic signed [9:0] samp_b;
        logic              refill_a;
        logic              refill_b;
        logic [5:0]        level_a;
        logic [5:0]        level_b;
    } t_audio_out;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_LONG, RX_MOSTLY} t_rx_mode;

    // sample queue predictor and result checker, channel 0 is A and 1 is B
    class fifo_scoreboard;
        logic [7:0]   mem [2][QDEPTH];
        logic [4:0]   rd [2];
        logic [5:0]   cnt [2];
        logic [7:0]   cur [2];
        logic         tsel [2];
        logic         fvol [2];
        t_audio_out   expected_out [$];
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  dropped;
        int unsigned  pops;
        int unsigned  dry_ticks;
        int unsigned  refills;

        function new();
            for (int c = 0; c < 2; c++) begin
                rd[c]   = '0;
                cnt[c]  = '0;
                cur[c]  = '0;
                tsel[c] = 1'b0;
                fvol[c] = 1'b0;
            end
            errors    = 0;
            checked   = 0;
            dropped   = 0;
            pops      = 0;
            dry_ticks = 0;
            refills   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic val);
            case (idx)
                CFG_TSEL_A: tsel[0] = val;
                CFG_TSEL_B: tsel[1] = val;
                CFG_FVOL_A: fvol[0] = val;
                CFG_FVOL_B: fvol[1] = val;
                default: ;
            endcase
        endfunction

        // bytes go in low first, counts above four act as four
        function void push_bytes(int ch, logic [31:0] data, logic [2:0] n);
            int unsigned lim;
            int unsigned i;
            logic [4:0]  wp;
            lim = 32'((n > MAX_BYTES) ? MAX_BYTES : n);
            for (i = 0; i < lim; i++) begin
                if (cnt[ch] < QDEPTH) begin
                    wp = rd[ch] + cnt[ch][4:0];
                    mem[ch][wp] = data[8*i +: 8];
                    cnt[ch]++;
                end else begin
                    dropped++;
                end
            end
        endfunction

        // one timer tick: pop if anything is there, report low level
        function logic pop_one(int ch);
            if (cnt[ch] != 0) begin
                cur[ch] = mem[ch][rd[ch]];
                rd[ch]++;
                cnt[ch]--;
                pops++;
            end else begin
                dry_ticks++;
            end
            return (cnt[ch] < REFILL_LVL);
        endfunction

        function logic signed [9:0] scaled(int ch);
            logic signed [9:0] wide;
            wide = {{2{cur[ch][7]}}, cur[ch]};
            return fvol[ch] ? (wide <<< 2) : (wide <<< 1);
        endfunction

        function void note_word(t_word w);
            t_audio_out e;
            e = '0;
            case (w.req)
                REQ_WRITE: begin
                    if (w.offset < B_WIN)
                        push_bytes(0, w.data, w.nbytes);
                    else if (w.offset < 2 * B_WIN)
                        push_bytes(1, w.data, w.nbytes);
                end
                REQ_TIMER: begin
                    // timers 2 and 3 never match a one-bit select
                    if ({1'b0, tsel[0]} == w.timer)
                        e.refill_a = pop_one(0);
                    if ({1'b0, tsel[1]} == w.timer)
                        e.refill_b = pop_one(1);
                end
                REQ_CLEAR: begin
                    for (int c = 0; c < 2; c++) begin
                        if (c == 0 ? w.clr_a : w.clr_b) begin
                            rd[c]  = '0;
                            cnt[c] = '0;
                            cur[c] = '0;
                        end
                    end
                end
                default: ;
            endcase
            refills += 32'(e.refill_a) + 32'(e.refill_b);
            e.samp_a  = scaled(0);
            e.samp_b  = scaled(1);
            e.level_a = cnt[0];
            e.level_b = cnt[1];
            expected_out.push_back(e);
        endfunction

        function void check_result(t_audio_out got);
            t_audio_out e;
            logic       bad;
            if (expected_out.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("tb: result word with nothing pending at %0t", $time);
                return;
            end
            e = expected_out.pop_front();
            checked++;
            bad = (got.samp_a !== e.samp_a) || (got.samp_b !== e.samp_b)
                || (got.refill_a !== e.refill_a) || (got.refill_b !== e.refill_b)
                || (got.level_a !== e.level_a) || (got.level_b !== e.level_b);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("tb: mismatch on word %0d at %0t", checked, $time);
                    $display("    exp a=%0d b=%0d refill=%b%b level=%0d/%0d",
                             e.samp_a, e.samp_b, e.refill_a, e.refill_b,
                             e.level_a, e.level_b);
                    $display("    got a=%0d b=%0d refill=%b%b level=%0d/%0d",
                             got.samp_a, got.samp_b, got.refill_a, got.refill_b,
                             got.level_a, got.level_b);
                end
            end
        endfunction

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic              i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_req_type;
    logic [3:0]        i_reg_offset;
    logic [31:0]       i_write_data;
    logic [2:0]        i_byte_count;
    logic [1:0]        i_timer_number;
    logic              i_clear_a;
    logic              i_clear_b;
    logic              o_valid;
    logic              i_ready;
    logic signed [9:0] o_out_sample_a;
    logic signed [9:0] o_out_sample_b;
    logic              o_refill_a;
    logic              o_refill_b;
    logic [5:0]        o_level_a;
    logic [5:0]        o_level_b;

    fifo_scoreboard sb;
    int unsigned    quiet_cycles = 0;
    t_rx_mode       rx_mode = RX_OPEN;
    int unsigned    rx_left = 0;
    int unsigned    rx_hold = 0;

    dual_audio_sample_fifo_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_reg_offset   (i_reg_offset),
        .i_write_data   (i_write_data),
        .i_byte_count   (i_byte_count),
        .i_timer_number (i_timer_number),
        .i_clear_a      (i_clear_a),
        .i_clear_b      (i_clear_b),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_sample_a (o_out_sample_a),
        .o_out_sample_b (o_out_sample_b),
        .o_refill_a     (o_refill_a),
        .o_refill_b     (o_refill_b),
        .o_level_a      (o_level_a),
        .o_level_b      (o_level_b)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side stalls, switching between stall styles every so often
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(40, 250);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:  i_ready = 1'b1;
            RX_COIN:  i_ready = 1'($urandom_range(0, 1));
            RX_LONG: begin
                if (rx_hold == 0) begin
                    i_ready = !i_ready;
                    rx_hold = i_ready ? $urandom_range(1, 4) : $urandom_range(1, 20);
                end else begin
                    rx_hold--;
                end
            end
            default:  i_ready = ($urandom_range(0, 9) != 0);
        endcase
    end

    // watch both handshakes, feed the scoreboard, and time out on a hang
    always @(posedge i_clk) begin
        t_word      seen_word;
        t_audio_out seen_out;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                seen_word = {i_req_type, i_reg_offset, i_write_data, i_byte_count,
                             i_timer_number, i_clear_a, i_clear_b};
                sb.note_word(seen_word);
            end
            if (o_valid && i_ready) begin
                seen_out = {o_out_sample_a, o_out_sample_b, o_refill_a, o_refill_b,
                            o_level_a, o_level_b};
                sb.check_result(seen_out);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("tb: no handshake for %0d cycles, %0d words still pending",
                         STALL_LIMIT, sb.pending());
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    function automatic t_word mk_word(logic [1:0] req, logic [3:0] off, logic [31:0] data,
                                      logic [2:0] n, logic [1:0] tmr, logic ca, logic cb);
        t_word w;
        w = {req, off, data, n, tmr, ca, cb};
        return w;
    endfunction

    // mostly well-formed traffic, the rest fully random noise
    function automatic t_word random_word(int unsigned wr_pct);
        t_word       w;
        int unsigned roll;
        w.req    = 2'($urandom_range(0, 3));
        w.offset = 4'($urandom_range(0, 15));
        w.data   = $urandom;
        w.nbytes = 3'($urandom_range(0, 7));
        w.timer  = 2'($urandom_range(0, 3));
        w.clr_a  = 1'($urandom_range(0, 1));
        w.clr_b  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 82) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                w.req = REQ_CLEAR;
            end else if (roll < wr_pct) begin
                w.req    = REQ_WRITE;
                w.offset = 4'($urandom_range(0, 2 * B_WIN - 1));
                case ($urandom_range(0, 2))
                    0:       w.nbytes = 3'd1;
                    1:       w.nbytes = 3'd2;
                    default: w.nbytes = 3'd4;
                endcase
            end else begin
                w.req   = REQ_TIMER;
                w.timer = {1'b0, ($urandom_range(0, 1) ? sb.tsel[1] : sb.tsel[0])};
            end
        end
        return w;
    endfunction

    // hold the word until it is taken
    task automatic send_word(input t_word w);
        @(negedge i_clk);
        i_valid        = 1'b1;
        i_req_type     = w.req;
        i_reg_offset   = w.offset;
        i_write_data   = w.data;
        i_byte_count   = w.nbytes;
        i_timer_number = w.timer;
        i_clear_a      = w.clr_a;
        i_clear_b      = w.clr_b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    // bit 0 select a, bit 1 select b, bit 2 volume a, bit 3 volume b
    task automatic apply_setting(input logic [3:0] s);
        write_reg(CFG_TSEL_A, s[0]);
        write_reg(CFG_TSEL_B, s[1]);
        write_reg(CFG_FVOL_A, s[2]);
        write_reg(CFG_FVOL_B, s[3]);
    endtask

    task automatic run_directed();
        int k;
        // sign extremes, odd and oversized counts, ignored offsets
        send_word(mk_word(REQ_WRITE, 4'd0, 32'h807F01FF, 3'd4, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_WRITE, 4'd3, 32'hFFFFFF00, 3'd1, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_WRITE, 4'd2, 32'h12345680, 3'd3, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_WRITE, 4'd1, 32'hDEADBEEF, 3'd0, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_WRITE, 4'd4, 32'h00007F80, 3'd2, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_WRITE, 4'd7, 32'hFFFFFFFF, 3'd7, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_WRITE, 4'd8, 32'hA5A5A5A5, 3'd4, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_WRITE, 4'd15, 32'h5A5A5A5A, 3'd4, 2'd0, 1'b0, 1'b0));
        // matched and unmatched timers, spare request code
        send_word(mk_word(REQ_TIMER, 4'd0, 32'h0, 3'd0, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_TIMER, 4'd0, 32'h0, 3'd0, 2'd1, 1'b0, 1'b0));
        send_word(mk_word(REQ_TIMER, 4'd0, 32'h0, 3'd0, 2'd2, 1'b1, 1'b1));
        send_word(mk_word(REQ_TIMER, 4'd0, 32'h0, 3'd0, 2'd3, 1'b0, 1'b0));
        send_word(mk_word(REQ_SPARE, 4'd0, 32'hFFFFFFFF, 3'd4, 2'd0, 1'b1, 1'b1));
        send_word(mk_word(REQ_TIMER, 4'd0, 32'h0, 3'd0, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_CLEAR, 4'd0, 32'h0, 3'd0, 2'd0, 1'b1, 1'b0));
        // fill a to the brim, then one more write that is dropped
        for (k = 0; k < QDEPTH / 4; k++)
            send_word(mk_word(REQ_WRITE, 4'(k % B_WIN), $urandom, 3'd4, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_WRITE, 4'd0, 32'h7F7F7F7F, 3'd5, 2'd0, 1'b0, 1'b0));
        send_word(mk_word(REQ_CLEAR, 4'd0, 32'h0, 3'd0, 2'd0, 1'b0, 1'b1));
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        int unsigned wr_pct;
        int unsigned k;
        bit          paused;
        t_word       w;
        sent   = 0;
        paused = 1'b0;
        while (sent < n) begin
            burst  = $urandom_range(1, 40);
            wr_pct = $urandom_range(25, 75);
            for (k = 0; k < burst && sent < n; k++) begin
                w = random_word(wr_pct);
                send_word(w);
                sent++;
            end
            // once per phase let everything come out before going on
            if (!paused && sent >= n / 2) begin
                drain_results();
                paused = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // wait for every result, then let the sequencer settle
    task automatic settle();
        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        logic [3:0] settings [5];
        int         p;
        sb             = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_TSEL_A;
        i_cfg_data     = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_req_type     = REQ_WRITE;
        i_reg_offset   = '0;
        i_write_data   = '0;
        i_byte_count   = '0;
        i_timer_number = '0;
        i_clear_a      = 1'b0;
        i_clear_b      = 1'b0;
        settings[0] = 4'b1111;
        settings[1] = 4'b0110;
        settings[2] = 4'b1001;
        settings[3] = 4'($urandom_range(0, 15));
        settings[4] = 4'($urandom_range(0, 15));

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        apply_setting(4'b0000);
        run_directed();
        run_random(PHASE_WORDS);
        settle();
        for (p = 0; p < 5; p++) begin
            apply_setting(settings[p]);
            run_random(PHASE_WORDS);
            settle();
        end

        $display("tb: %0d words checked across six register settings, %0d mismatches",
                 sb.checked, sb.errors);
        $display("tb: %0d pops, %0d ticks on an empty queue, %0d bytes dropped when full",
                 sb.pops, sb.dry_ticks, sb.dropped);
        $display("tb: %0d refill requests seen", sb.refills);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> dual_audio_sample_fifo_core.f
hdl/dasf_pkg.sv
hdl/dasf_ram.sv
hdl/dasf_chan.sv
hdl/dual_audio_sample_fifo_core.sv
sim/tb.sv
